// ----- design/sha512_pkg.sv -----
// sha512_pkg: shared types, constants and round functions of the sha-512 engine
// round constant and initial hash tables, padding helper, sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha512_pkg;

    localparam int WORD_W     = 64;
    localparam int BLK_WORDS  = 16;
    localparam int HASH_WORDS = 8;

    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] LAST_FILL  = 4'd15;
    localparam logic [3:0] LEN_FILL   = 4'd14;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [6:0] LOAD_END   = 7'd8;
    localparam logic [6:0] SCHED_END  = 7'd80;
    localparam logic [6:0] ROUND_END  = 7'd81;
    localparam logic [6:0] SCHED_LOAD = 7'd16;
    localparam logic [63:0] PAD_MARK  = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_HI,
        ST_PAD_LO,
        ST_LOAD,
        ST_ROUND,
        ST_WB,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

    function automatic logic [63:0] big_s0(input logic [63:0] x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_s1(input logic [63:0] x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] ch_f(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic logic [63:0] maj_f(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    // keeps the first n bytes and, when n is below eight, places the 0x80 marker right after them
    function automatic logic [63:0] pad_word(input logic [63:0] data, input logic [3:0] n);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
                w[63 - 8 * i -: 8] = data[63 - 8 * i -: 8];
            else if (4'(i) == n)
                w[63 - 8 * i -: 8] = 8'h80;
        end
        return w;
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] h;
        case (idx)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            default: h = 64'h5be0cd19137e2179;
        endcase
        return h;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] idx);
        logic [63:0] k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/sha512_hash_engine_core.sv -----
// sha512_hash_engine_core: sha-512 over a stream of big-endian 64-bit message words
// uses sha512_pkg and two sha512_ram instances (block buffer, hash value)
//
// input channel: in_valid / in_stall carry data_word, byte_count and last. an item
// with fewer than eight valid bytes, or with last set, ends the message. an empty
// non-final item is taken and ignored.
// output channel: out_valid / out_stall carry the eight digest words of each message,
// word_index 0 first, digest_last on word 7.
// a word is taken and written to the block ram; every sixteenth word starts a
// compression (hash load, then schedule and rounds at one round per cycle, then
// hash read-modify-write back), during which in_stall is high. the final item adds
// padding words, one or two compressions, then the eight digest words; in_stall
// stays high from the final item until the last digest word is loaded.
// when out_stall holds a digest word, the sequencer waits before loading the next;
// the eighth word may still wait while the next message is taken in.
// reset (rst_n low, asynchronous) empties the block, clears the byte count, sets the
// hash value back to the initial constants and drops out_valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sha512_hash_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] digest_word,
    output logic      [2:0]  word_index,
    output logic             digest_last
);

    import sha512_pkg::*;

    state_t      state_reg, state_next;
    state_t      resume_reg, resume_next;
    logic [3:0]  fill_reg, fill_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] len_lo_reg, len_lo_next;
    logic [63:0] len_hi_reg, len_hi_next;
    logic [7:0]  hv_valid_reg, hv_valid_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;

    logic [63:0] v_reg [HASH_WORDS];
    logic [63:0] v_next [HASH_WORDS];
    logic [63:0] w_reg [BLK_WORDS];
    logic [63:0] w_next [BLK_WORDS];
    logic [63:0] wk_reg, wk_next;
    logic [63:0] dig_reg, dig_next;
    logic [2:0]  widx_reg, widx_next;
    logic [2:0]  hv_ridx_reg;

    logic        blk_we;
    logic [3:0]  blk_raddr;
    logic [63:0] blk_wdata;
    logic [63:0] blk_q;
    logic        hv_we;
    logic [2:0]  hv_waddr;
    logic [2:0]  hv_raddr;
    logic [63:0] hv_wdata;
    logic [63:0] hv_q;
    logic [63:0] hv_data;

    logic        push;
    logic [63:0] push_data;
    logic [3:0]  n_sat;
    logic        fin_eff;
    logic [64:0] len_sum;
    logic [6:0]  sidx;
    logic [2:0]  vidx;
    logic [63:0] w_new;
    logic [63:0] t1;
    logic [63:0] t2;

    sha512_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_blk_ram (
        .clk     (clk),
        .wr_en   (blk_we),
        .wr_addr (fill_reg),
        .wr_data (blk_wdata),
        .rd_addr (blk_raddr),
        .rd_data (blk_q)
    );

    sha512_ram #(.WIDTH(WORD_W), .DEPTH(HASH_WORDS)) u_hv_ram (
        .clk     (clk),
        .wr_en   (hv_we),
        .wr_addr (hv_waddr),
        .wr_data (hv_wdata),
        .rd_addr (hv_raddr),
        .rd_data (hv_q)
    );

    assign hv_data     = hv_valid_reg[hv_ridx_reg] ? hv_q : init_hash(hv_ridx_reg);
    assign n_sat       = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
    assign fin_eff     = last || (n_sat < FULL_BYTES);
    assign len_sum     = {1'b0, len_lo_reg} + 65'(n_sat);
    assign sidx        = cnt_reg - 7'd1;
    assign vidx        = sidx[2:0];
    assign t1          = v_reg[7] + big_s1(v_reg[4]) + ch_f(v_reg[4], v_reg[5], v_reg[6])
                         + wk_reg;
    assign t2          = big_s0(v_reg[0]) + maj_f(v_reg[0], v_reg[1], v_reg[2]);
    assign w_new       = (sidx < SCHED_LOAD) ? blk_q
                         : w_reg[0] + small_s0(w_reg[1]) + w_reg[9] + small_s1(w_reg[14]);

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digest_word = dig_reg;
    assign word_index  = widx_reg;
    assign digest_last = (widx_reg == LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            resume_reg    <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            len_lo_reg    <= '0;
            len_hi_reg    <= '0;
            hv_valid_reg  <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            len_lo_reg    <= len_lo_next;
            len_hi_reg    <= len_hi_next;
            hv_valid_reg  <= hv_valid_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        w_reg       <= w_next;
        wk_reg      <= wk_next;
        dig_reg     <= dig_next;
        widx_reg    <= widx_next;
        hv_ridx_reg <= hv_raddr;
    end

    always_comb
    begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        len_lo_next    = len_lo_reg;
        len_hi_next    = len_hi_reg;
        hv_valid_next  = hv_valid_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        v_next         = v_reg;
        w_next         = w_reg;
        wk_next        = wk_reg;
        dig_next       = dig_reg;
        widx_next      = widx_reg;
        push           = 1'b0;
        push_data      = '0;
        blk_raddr      = cnt_reg[3:0];
        hv_raddr       = cnt_reg[2:0];
        hv_we          = 1'b0;
        hv_waddr       = vidx;
        hv_wdata       = hv_data + v_reg[vidx];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !(n_sat == 4'd0 && !last))
                begin
                    len_lo_next = len_sum[63:0];
                    len_hi_next = len_hi_reg + 64'(len_sum[64]);
                    push        = 1'b1;
                    push_data   = pad_word(data_word, n_sat);
                    if (!fin_eff)
                        state_next = ST_IDLE;
                    else if (n_sat == FULL_BYTES)
                        state_next = ST_PAD_MARK;
                    else
                        state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_MARK:
            begin
                push       = 1'b1;
                push_data  = PAD_MARK;
                state_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == LEN_FILL)
                    state_next = ST_PAD_HI;
                else
                    push = 1'b1;
            end
            ST_PAD_HI:
            begin
                push       = 1'b1;
                push_data  = {len_hi_reg[60:0], len_lo_reg[63:61]};
                state_next = ST_PAD_LO;
            end
            ST_PAD_LO:
            begin
                push         = 1'b1;
                push_data    = {len_lo_reg[60:0], 3'b000};
                out_idx_next = '0;
                state_next   = ST_OUT_RD;
            end
            ST_LOAD:
            begin
                if (cnt_reg != '0)
                    v_next[vidx] = hv_data;
                if (cnt_reg == LOAD_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_ROUND:
            begin
                if (cnt_reg != '0 && cnt_reg <= SCHED_END)
                begin
                    wk_next = w_new + round_k(sidx);
                    for (int i = 0; i < BLK_WORDS - 1; i++)
                        w_next[i] = w_reg[i + 1];
                    w_next[BLK_WORDS - 1] = w_new;
                end
                if (cnt_reg >= 7'd2)
                begin
                    v_next[7] = v_reg[6];
                    v_next[6] = v_reg[5];
                    v_next[5] = v_reg[4];
                    v_next[4] = v_reg[3] + t1;
                    v_next[3] = v_reg[2];
                    v_next[2] = v_reg[1];
                    v_next[1] = v_reg[0];
                    v_next[0] = t1 + t2;
                end
                if (cnt_reg == ROUND_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_WB;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_WB:
            begin
                if (cnt_reg != '0)
                begin
                    hv_we               = 1'b1;
                    hv_valid_next[vidx] = 1'b1;
                end
                if (cnt_reg == LOAD_END)
                begin
                    cnt_next   = '0;
                    state_next = resume_reg;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            ST_OUT_RD:
            begin
                hv_raddr = out_idx_reg;
                if (!out_valid_reg || !out_stall)
                    state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                dig_next       = hv_data;
                widx_next      = out_idx_reg;
                out_valid_next = 1'b1;
                if (out_idx_reg == LAST_WORD)
                begin
                    hv_valid_next = '0;
                    len_lo_next   = '0;
                    len_hi_next   = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    state_next   = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a full block diverts to compression and comes back afterwards
        if (push)
        begin
            if (fill_reg == LAST_FILL)
            begin
                fill_next   = '0;
                resume_next = state_next;
                cnt_next    = '0;
                state_next  = ST_LOAD;
            end
            else
                fill_next = fill_reg + 4'd1;
        end
    end

    assign blk_we    = push;
    assign blk_wdata = push_data;

endmodule

`default_nettype wire

// ----- design/sha512_ram.sv -----
// sha512_ram: generic simple dual-port ram, one write and one registered read port
// storage for the block buffer and the hash value; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sha512_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- tb/tb_sha512_hash_engine_core.sv -----
// tb: self-checking bench for sha512_hash_engine_core, stand-alone, depends only on the rtl
// items flow from a queue through a clocked driver, digests are checked by a clocked monitor
// against a sha-512 predictor kept in the bench, with random input gaps and random output stalls
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic [80*64-1:0] ROUND_CONST = {
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [8*64-1:0] START_CHAIN = {
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] PAD_BYTE = 64'h80;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        fin;
        bit          drain;
    } msg_word_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] data_word = '0;
    logic [3:0]  byte_count = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    msg_word_t    msg_words_q[$];
    digest_word_t digest_q[$];
    msg_word_t    cur_word;
    digest_word_t exp_word;

    logic [63:0]  chain_h [0:7];
    logic [63:0]  blk_words [0:15];
    int           blk_fill;
    logic [127:0] msg_len;

    int           err_count = 0;
    int unsigned  cycle_cnt = 0;
    int           tx_gap = 0;
    bit           tx_calm = 1'b0;
    int           rx_hold = 0;
    int           rx_next;
    bit           rx_calm = 1'b0;

    sha512_hash_engine_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] ror64(input logic [63:0] x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

    task automatic clear_chain();
        for (int j = 0; j < 8; j++)
            chain_h[j] = START_CHAIN[(7 - j) * 64 +: 64];
        for (int j = 0; j < 16; j++)
            blk_words[j] = '0;
        blk_fill = 0;
        msg_len = '0;
    endtask

    task automatic compress_blk();
        logic [63:0] w [0:79];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = blk_words[r];
        for (int r = 16; r < 80; r++)
            w[r] = w[r - 16] + (ror64(w[r - 15], 1) ^ ror64(w[r - 15], 8) ^ (w[r - 15] >> 7))
                 + w[r - 7] + (ror64(w[r - 2], 19) ^ ror64(w[r - 2], 61) ^ (w[r - 2] >> 6));
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int r = 0; r < 80; r++)
        begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[(79 - r) * 64 +: 64] + w[r];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic absorb_word(input logic [63:0] w);
        blk_words[blk_fill] = w;
        blk_fill++;
        if (blk_fill == 16)
        begin
            compress_blk();
            blk_fill = 0;
        end
    endtask

    // advances the hash by one accepted item, queues the digest when the message ends
    task automatic hash_item(input logic [63:0] w, input logic [3:0] nb, input logic fin_in);
        int           n;
        bit           fin;
        logic [63:0]  kept;
        logic [127:0] bits;
        digest_word_t dw;
        n = (nb > 4'd8) ? 8 : int'(nb);
        fin = fin_in;
        if (n == 0 && !fin)
            return;
        if (n < 8)
            fin = 1'b1;
        msg_len = msg_len + 128'(n);
        if (!fin)
        begin
            absorb_word(w);
            return;
        end
        if (n == 8)
        begin
            absorb_word(w);
            absorb_word(PAD_BYTE << 56);
        end
        else
        begin
            kept = (n == 0) ? '0 : (w & ({64{1'b1}} << (64 - 8 * n)));
            absorb_word(kept | (PAD_BYTE << (56 - 8 * n)));
        end
        if (blk_fill > 14)
            while (blk_fill != 0)
                absorb_word('0);
        while (blk_fill < 14)
            absorb_word('0);
        bits = msg_len << 3;
        absorb_word(bits[127:64]);
        absorb_word(bits[63:0]);
        for (int j = 0; j < 8; j++)
        begin
            dw.word = chain_h[j];
            dw.idx = 3'(j);
            dw.fin = (j == 7);
            digest_q.push_back(dw);
        end
        clear_chain();
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void queue_word(input logic [63:0] w, input logic [3:0] nb,
                                       input logic fin, input bit drain);
        msg_word_t m;
        m.word = w;
        m.nbytes = nb;
        m.fin = fin;
        m.drain = drain;
        msg_words_q.push_back(m);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_word <= '0;
            byte_count <= '0;
            last <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                hash_item(data_word, byte_count, last);
            if (!in_valid || !in_stall)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (msg_words_q.size() != 0 &&
                         !(msg_words_q[0].drain && digest_q.size() != 0))
                begin
                    cur_word = msg_words_q.pop_front();
                    in_valid <= 1'b1;
                    data_word <= cur_word.word;
                    byte_count <= cur_word.nbytes;
                    last <= cur_word.fin;
                    if ($urandom_range(0, 31) == 0)
                        tx_calm = !tx_calm;
                    tx_gap <= tx_calm ? 0 : int'($urandom_range(0, 15));
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end
        else
        begin
            rx_next = rx_hold;
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest word %h index %0d",
                                              digest_word, word_index));
                end
                else
                begin
                    exp_word = digest_q.pop_front();
                    if (digest_word !== exp_word.word)
                        report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                                  digest_word, exp_word.word, exp_word.idx));
                    if (word_index !== exp_word.idx)
                        report_mismatch($sformatf("word_index %0d, expected %0d",
                                                  word_index, exp_word.idx));
                    if (digest_last !== exp_word.fin)
                        report_mismatch($sformatf("digest_last %b, expected %b (index %0d)",
                                                  digest_last, exp_word.fin, exp_word.idx));
                end
                if ($urandom_range(0, 23) == 0)
                    rx_calm = !rx_calm;
                rx_next = rx_calm ? 0 : int'($urandom_range(0, 15));
            end
            else if (rx_next != 0)
            begin
                rx_next = rx_next - 1;
            end
            rx_hold <= rx_next;
            out_stall <= (rx_next != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("** sha512_hash_engine_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int          made;
        int          nwords;
        int          pick;
        bit          drain;
        bit          mid_drained;
        logic [3:0]  nb;
        clear_chain();

        // directed messages
        queue_word('0, 4'd0, 1'b1, 1'b0);
        queue_word(64'h616263ff_ffffffff, 4'd3, 1'b1, 1'b0);
        queue_word({64{1'b1}}, 4'd0, 1'b0, 1'b0);
        queue_word({64{1'b1}}, 4'd15, 1'b0, 1'b0);
        queue_word('0, 4'd9, 1'b1, 1'b0);
        queue_word(64'h01234567_89abcdef, 4'd5, 1'b0, 1'b0);
        queue_word({64{1'b1}}, 4'd8, 1'b1, 1'b0);
        queue_word('0, 4'd1, 1'b1, 1'b0);
        // fourteen full words then a 7-byte tail, padding spills into an extra block
        for (int i = 0; i < 14; i++)
            queue_word(rand_word(), 4'd8, 1'b0, 1'b0);
        queue_word(rand_word(), 4'd7, 1'b1, 1'b0);

        // random messages, mostly well formed
        made = 0;
        drain = 1'b1;
        mid_drained = 1'b0;
        while (made < 400)
        begin
            if (made >= 200 && !mid_drained)
            begin
                drain = 1'b1;
                mid_drained = 1'b1;
            end
            nwords = ($urandom_range(0, 7) == 0) ? int'($urandom_range(17, 40))
                                                 : int'($urandom_range(1, 17));
            for (int i = 0; i < nwords - 1; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    queue_word(rand_word(), 4'd0, 1'b0, 1'b0);
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    nb = 4'($urandom_range(1, 7));
                else if (pick < 5)
                    nb = 4'($urandom_range(9, 15));
                else
                    nb = 4'd8;
                queue_word(rand_word(), nb, 1'b0, drain);
                drain = 1'b0;
                made++;
            end
            queue_word(rand_word(), 4'($urandom_range(0, 15)), 1'b1, drain);
            drain = 1'b0;
            made++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so driver and monitor updates have settled
        while (!(msg_words_q.size() == 0 && !in_valid && digest_q.size() == 0))
            @(negedge clk);
        repeat (300) @(posedge clk);

        if (err_count == 0)
            $display("** sha512_hash_engine_core: PASSED **");
        else
            $display("** sha512_hash_engine_core: FAILED **");
        $finish;
    end

endmodule
